### hdl/keystroke_injection_sequencer_unit_macros.svh
// Assertion macros shared by the keystroke injection sequencer modules.
// Include where concurrent checks are written; no other dependencies.
`ifndef KEYSTROKE_INJECTION_SEQUENCER_UNIT_MACROS_SVH
`define KEYSTROKE_INJECTION_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KSIU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("keystroke sequencer check failed");
`define KSIU_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("keystroke sequencer forbidden condition");
`else
`define KSIU_ASSERT(lbl, clk, rst_n, prop)
`define KSIU_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### hdl/ksi_pkg.sv
// Shared types, constants and keymap lookup for the keystroke sequencer.
// No dependencies.
`default_nettype none
package ksi_pkg;
	localparam int QUEUE_DEPTH = 256;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [1:0] REG_HOLD  = 2'd0;
	localparam logic [1:0] REG_GAP   = 2'd1;
	localparam logic [1:0] REG_START = 2'd2;

	localparam logic [7:0] HOLD_RST  = 8'd2;
	localparam logic [7:0] GAP_RST   = 8'd1;
	localparam logic [7:0] START_RST = 8'd3;

	localparam logic [3:0] MODKEY_ROW = 4'd2;
	localparam logic [2:0] MODKEY_COL = 3'd5;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	typedef struct packed {
		logic       valid;
		logic       shift;
		logic [3:0] row;
		logic [2:0] col;
	} ksi_key_t;

	typedef struct packed {
		logic       is_release;
		logic [3:0] key_row;
		logic [2:0] key_col;
		logic       last;
	} ksi_beat_t;

	typedef struct packed {
		logic start;
		logic append;
		logic timer_dec;
		logic eval;
		logic beat_adv;
	} ksi_cmd_t;

	typedef struct packed {
		logic exhausted;
		logic timer_zero;
		logic two_beats;
	} ksi_stat_t;

	function automatic ksi_key_t mk(input logic [3:0] r, input logic [2:0] c,
		input logic s);
		ksi_key_t k;
		k.valid = 1'b1;
		k.shift = s;
		k.row   = r;
		k.col   = c;
		return k;
	endfunction

	// letters by low five bits: 1 is a, 26 is z
	function automatic ksi_key_t letter_key(input logic [4:0] n);
		ksi_key_t k;
		k = '0;
		case (n)
			5'd1:    k = mk(4'd8, 3'd5, 1'b0);
			5'd2:    k = mk(4'd6, 3'd6, 1'b0);
			5'd3:    k = mk(4'd7, 3'd6, 1'b0);
			5'd4:    k = mk(4'd7, 3'd5, 1'b0);
			5'd5:    k = mk(4'd7, 3'd2, 1'b0);
			5'd6:    k = mk(4'd6, 3'd5, 1'b0);
			5'd7:    k = mk(4'd6, 3'd4, 1'b0);
			5'd8:    k = mk(4'd5, 3'd4, 1'b0);
			5'd9:    k = mk(4'd4, 3'd3, 1'b0);
			5'd10:   k = mk(4'd5, 3'd5, 1'b0);
			5'd11:   k = mk(4'd4, 3'd5, 1'b0);
			5'd12:   k = mk(4'd4, 3'd4, 1'b0);
			5'd13:   k = mk(4'd4, 3'd6, 1'b0);
			5'd14:   k = mk(4'd5, 3'd6, 1'b0);
			5'd15:   k = mk(4'd4, 3'd2, 1'b0);
			5'd16:   k = mk(4'd3, 3'd3, 1'b0);
			5'd17:   k = mk(4'd8, 3'd3, 1'b0);
			5'd18:   k = mk(4'd6, 3'd2, 1'b0);
			5'd19:   k = mk(4'd7, 3'd4, 1'b0);
			5'd20:   k = mk(4'd6, 3'd3, 1'b0);
			5'd21:   k = mk(4'd5, 3'd2, 1'b0);
			5'd22:   k = mk(4'd6, 3'd7, 1'b0);
			5'd23:   k = mk(4'd7, 3'd3, 1'b0);
			5'd24:   k = mk(4'd7, 3'd7, 1'b0);
			5'd25:   k = mk(4'd5, 3'd3, 1'b0);
			5'd26:   k = mk(4'd8, 3'd7, 1'b0);
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic ksi_key_t keymap(input logic [6:0] ch);
		ksi_key_t k;
		k = '0;
		if (ch inside {[7'h41:7'h5A]}) begin
			k = letter_key(ch[4:0]);
			k.shift = 1'b1;
		end else if (ch inside {[7'h61:7'h7A]}) begin
			k = letter_key(ch[4:0]);
		end else begin
			case (ch)
				7'h0A:   k = mk(4'd2, 3'd2, 1'b0);
				7'h20:   k = mk(4'd5, 3'd7, 1'b0);
				7'h30:   k = mk(4'd4, 3'd0, 1'b0);
				7'h31:   k = mk(4'd8, 3'd0, 1'b0);
				7'h32:   k = mk(4'd8, 3'd1, 1'b0);
				7'h33:   k = mk(4'd7, 3'd1, 1'b0);
				7'h34:   k = mk(4'd7, 3'd0, 1'b0);
				7'h35:   k = mk(4'd6, 3'd1, 1'b0);
				7'h36:   k = mk(4'd6, 3'd0, 1'b0);
				7'h37:   k = mk(4'd5, 3'd1, 1'b0);
				7'h38:   k = mk(4'd5, 3'd0, 1'b0);
				7'h39:   k = mk(4'd4, 3'd1, 1'b0);
				7'h2D:   k = mk(4'd3, 3'd1, 1'b0);
				7'h3D:   k = mk(4'd3, 3'd0, 1'b0);
				7'h3B:   k = mk(4'd3, 3'd5, 1'b0);
				7'h27:   k = mk(4'd3, 3'd4, 1'b0);
				7'h2F:   k = mk(4'd3, 3'd6, 1'b0);
				7'h2E:   k = mk(4'd3, 3'd7, 1'b0);
				7'h2C:   k = mk(4'd4, 3'd7, 1'b0);
				7'h5B:   k = mk(4'd3, 3'd2, 1'b0);
				7'h5D:   k = mk(4'd2, 3'd1, 1'b0);
				7'h5C:   k = mk(4'd2, 3'd6, 1'b0);
				7'h21:   k = mk(4'd8, 3'd0, 1'b1);
				7'h22:   k = mk(4'd8, 3'd1, 1'b1);
				7'h24:   k = mk(4'd7, 3'd0, 1'b1);
				7'h25:   k = mk(4'd6, 3'd1, 1'b1);
				7'h26:   k = mk(4'd6, 3'd0, 1'b1);
				7'h28:   k = mk(4'd5, 3'd0, 1'b1);
				7'h29:   k = mk(4'd4, 3'd1, 1'b1);
				7'h3A:   k = mk(4'd3, 3'd5, 1'b1);
				7'h3F:   k = mk(4'd3, 3'd6, 1'b1);
				7'h3E:   k = mk(4'd3, 3'd7, 1'b1);
				7'h3C:   k = mk(4'd4, 3'd7, 1'b1);
				default: k = '0;
			endcase
		end
		return k;
	endfunction
endpackage
`default_nettype wire

### hdl/ksi_dpath.sv
// Datapath: config registers, character queue memory, counters, timer,
// keymap lookup and output beat registers. Depends on ksi_pkg.
`default_nettype none
`include "keystroke_injection_sequencer_unit_macros.svh"
module ksi_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire logic [7:0]        char_code,
	input  wire ksi_pkg::ksi_cmd_t cmd,
	output ksi_pkg::ksi_stat_t     stat,
	output ksi_pkg::ksi_beat_t     beat
);
	logic [7:0] hold_q, gap_q, start_q, timer_q;
	logic [ksi_pkg::CNT_W-1:0] fill_q, read_q;
	logic key_down_q;
	logic [6:0] mem [ksi_pkg::QUEUE_DEPTH];
	logic [6:0] rd_q;
	ksi_pkg::ksi_beat_t out_q, next_q;
	ksi_pkg::ksi_key_t in_key, q_key;
	ksi_pkg::ksi_beat_t first, second;
	logic append_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= ksi_pkg::HOLD_RST;
			gap_q   <= ksi_pkg::GAP_RST;
			start_q <= ksi_pkg::START_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ksi_pkg::REG_HOLD:  hold_q  <= cfg_data;
				ksi_pkg::REG_GAP:   gap_q   <= cfg_data;
				ksi_pkg::REG_START: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_key = ksi_pkg::keymap(char_code[6:0]);
	assign append_ok = !char_code[7] && (char_code != ksi_pkg::CHAR_CR) && in_key.valid
		&& (fill_q != ksi_pkg::CNT_W'(ksi_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.append && append_ok) begin
			mem[fill_q[ksi_pkg::IDX_W-1:0]] <= char_code[6:0];
		end
		rd_q <= mem[read_q[ksi_pkg::IDX_W-1:0]];
	end

	assign q_key = ksi_pkg::keymap(rd_q);

	always_comb begin
		if (!key_down_q) begin
			second = ksi_pkg::ksi_beat_t'{1'b0, q_key.row, q_key.col, 1'b1};
			if (q_key.shift) begin
				first = ksi_pkg::ksi_beat_t'{1'b0, ksi_pkg::MODKEY_ROW,
					ksi_pkg::MODKEY_COL, 1'b0};
			end else begin
				first = second;
			end
		end else begin
			first  = ksi_pkg::ksi_beat_t'{1'b1, q_key.row, q_key.col, !q_key.shift};
			second = ksi_pkg::ksi_beat_t'{1'b1, ksi_pkg::MODKEY_ROW,
				ksi_pkg::MODKEY_COL, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			read_q     <= '0;
			timer_q    <= '0;
			key_down_q <= 1'b0;
		end else if (cmd.start) begin
			fill_q     <= '0;
			read_q     <= '0;
			timer_q    <= start_q;
			key_down_q <= 1'b0;
		end else if (cmd.append && append_ok) begin
			fill_q <= fill_q + 1'b1;
		end else if (cmd.timer_dec) begin
			timer_q <= timer_q - 1'b1;
		end else if (cmd.eval) begin
			key_down_q <= !key_down_q;
			if (key_down_q) begin
				read_q  <= read_q + 1'b1;
				timer_q <= gap_q;
			end else begin
				timer_q <= hold_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			out_q  <= first;
			next_q <= second;
		end else if (cmd.beat_adv) begin
			out_q <= next_q;
		end
	end

	assign stat.exhausted  = read_q >= fill_q;
	assign stat.timer_zero = timer_q == '0;
	assign stat.two_beats  = q_key.shift;
	assign beat = out_q;

	`KSIU_ASSERT(a_read_within_fill, clk, arst_n, read_q <= fill_q)
	`KSIU_ASSERT(a_eval_toggles_key, clk, arst_n, cmd.eval |=> key_down_q != $past(key_down_q))
endmodule
`default_nettype wire

### hdl/ksi_ctrl.sv
// Controller: input handshake, operation decode and beat sequencing.
// Depends on ksi_pkg; drives the datapath through ksi_cmd_t.
`default_nettype none
`include "keystroke_injection_sequencer_unit_macros.svh"
module ksi_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	input  wire logic [1:0]         op,
	output logic                    s_axis_tready,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	input  wire ksi_pkg::ksi_stat_t stat,
	output ksi_pkg::ksi_cmd_t       cmd
);
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EVAL   = 4'b0010,
		S_BEAT_A = 4'b0100,
		S_BEAT_B = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic in_go;

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = (state_q == S_BEAT_A) || (state_q == S_BEAT_B);
	assign in_go = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_go) begin
					case (op)
						ksi_pkg::OP_START:  cmd.start = 1'b1;
						ksi_pkg::OP_APPEND: cmd.append = 1'b1;
						ksi_pkg::OP_TICK: begin
							if (!stat.exhausted) begin
								if (!stat.timer_zero) begin
									cmd.timer_dec = 1'b1;
								end else begin
									state_d = S_EVAL;
								end
							end
						end
						default: ;
					endcase
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = stat.two_beats ? S_BEAT_A : S_BEAT_B;
			end
			S_BEAT_A: begin
				if (m_axis_tready) begin
					cmd.beat_adv = 1'b1;
					state_d = S_BEAT_B;
				end
			end
			S_BEAT_B: begin
				if (m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`KSIU_NEVER(a_no_overlap, clk, arst_n, s_axis_tready && m_axis_tvalid)
	`KSIU_ASSERT(a_eval_to_beat, clk, arst_n,
		state_q == S_EVAL |=> (state_q == S_BEAT_A || state_q == S_BEAT_B))
endmodule
`default_nettype wire

### hdl/keystroke_injection_sequencer_unit.sv
// Top level of the keystroke injection sequencer.
// Instantiates ksi_ctrl and ksi_dpath; depends on ksi_pkg.
`default_nettype none
// A start or an append beat, or a tick that finds the queue exhausted or the
// timer still running, is accepted and handled in the idle state. A tick that
// presses or releases a key is accepted, then evaluated in S_EVAL from the
// registered read of the character queue, then sent as one output beat for a
// plain key or two for a shifted one, each held until the sink is ready. No
// new input beat is taken until the last output beat of a tick is gone.
module keystroke_injection_sequencer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] char_code
	input  wire logic [1:0] s_axis_tuser,  // [1:0] operation
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [0] is_release, [4:1] key_row, [7:5] key_col
	output logic            m_axis_tlast
);
	ksi_pkg::ksi_cmd_t  cmd;
	ksi_pkg::ksi_stat_t stat;
	ksi_pkg::ksi_beat_t beat;

	ksi_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.op            (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	ksi_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_code (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.beat      (beat)
	);

	assign m_axis_tdata = {beat.key_col, beat.key_row, beat.is_release};
	assign m_axis_tlast = beat.last;
endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for keystroke_injection_sequencer_unit: drives start, append and tick beats
// with random bursts and sink stalls, predicts every matrix event and checks each one.
// Depends on ksi_pkg and the sequencer RTL only.
module tb;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1050;

	localparam int LET_ROW[26] = '{8, 6, 7, 7, 7, 6, 6, 5, 4, 5, 4, 4, 4,
		5, 4, 3, 8, 6, 7, 6, 5, 6, 7, 7, 5, 8};
	localparam int LET_COL[26] = '{5, 6, 6, 5, 2, 5, 4, 4, 3, 5, 5, 4, 6,
		6, 2, 3, 3, 2, 4, 3, 2, 7, 3, 7, 3, 7};
	localparam int DIG_ROW[10] = '{4, 8, 8, 7, 7, 6, 6, 5, 5, 4};
	localparam int DIG_COL[10] = '{0, 0, 1, 1, 0, 1, 0, 1, 0, 1};

	typedef struct packed {
		logic       ok;
		logic       shift;
		logic [3:0] row;
		logic [2:0] col;
	} key_code_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
	} in_beat_t;

	typedef struct packed {
		logic       rel;
		logic [3:0] row;
		logic [2:0] col;
		logic       last;
	} key_event_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = ksi_pkg::REG_HOLD;
	logic [7:0] cfg_data = 8'd0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;   // [7:0] char_code
	logic [1:0] s_axis_tuser = ksi_pkg::OP_TICK; // [1:0] operation
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [0] is_release, [4:1] key_row, [7:5] key_col
	logic       m_axis_tlast;

	keystroke_injection_sequencer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	key_code_t  key_table [0:127];
	logic [7:0] typeable [$];

	logic [7:0] hold_ticks = ksi_pkg::HOLD_RST;
	logic [7:0] gap_ticks = ksi_pkg::GAP_RST;
	logic [7:0] delay_ticks = ksi_pkg::START_RST;
	logic [6:0] char_store [0:ksi_pkg::QUEUE_DEPTH-1];
	int         fill_cnt = 0;
	int         play_pos = 0;
	logic [7:0] frame_wait = 8'd0;
	logic       key_held = 1'b0;

	in_beat_t   pending_beats [$];
	key_event_t key_events [$];

	logic in_fire = 1'b0;
	int   gap_left = 0;
	int   burst_left = 0;
	int   rx_cnt = 0;
	int   rx_mode = 0;
	int   cycle_count = 0;
	int   errors = 0;
	int   events_checked = 0;
	int   beats_sent = 0;
	int   useful_items = 0;
	int   phases = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void put_key(input int code, input int r, input int c, input bit s);
		key_table[code].ok    = 1'b1;
		key_table[code].shift = s;
		key_table[code].row   = r[3:0];
		key_table[code].col   = c[2:0];
	endfunction

	function automatic bit is_typeable(input logic [7:0] ch);
		return !ch[7] && ch != ksi_pkg::CHAR_CR && key_table[ch[6:0]].ok;
	endfunction

	function automatic void emit_event(input logic rel, input logic [3:0] row,
		input logic [2:0] col, input logic last);
		key_event_t ev;
		ev.rel  = rel;
		ev.row  = row;
		ev.col  = col;
		ev.last = last;
		key_events.push_back(ev);
	endfunction

	function automatic void advance_keyboard(input logic [1:0] op, input logic [7:0] ch);
		key_code_t k;
		if (op == ksi_pkg::OP_START) begin
			fill_cnt   = 0;
			play_pos   = 0;
			frame_wait = delay_ticks;
			key_held   = 1'b0;
		end else if (op == ksi_pkg::OP_APPEND) begin
			if (is_typeable(ch) && fill_cnt < ksi_pkg::QUEUE_DEPTH) begin
				char_store[fill_cnt] = ch[6:0];
				fill_cnt++;
			end
		end else if (op == ksi_pkg::OP_TICK && play_pos < fill_cnt) begin
			if (frame_wait != 0) begin
				frame_wait--;
			end else begin
				k = key_table[char_store[play_pos]];
				if (!key_held) begin
					if (k.shift)
						emit_event(1'b0, ksi_pkg::MODKEY_ROW, ksi_pkg::MODKEY_COL, 1'b0);
					emit_event(1'b0, k.row, k.col, 1'b1);
					key_held   = 1'b1;
					frame_wait = hold_ticks;
				end else begin
					emit_event(1'b1, k.row, k.col, !k.shift);
					if (k.shift)
						emit_event(1'b1, ksi_pkg::MODKEY_ROW, ksi_pkg::MODKEY_COL, 1'b1);
					key_held   = 1'b0;
					play_pos++;
					frame_wait = gap_ticks;
				end
			end
		end
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	function automatic void enqueue_beat(input logic [1:0] op, input logic [7:0] ch);
		in_beat_t b;
		b.op = op;
		b.ch = ch;
		pending_beats.push_back(b);
		beats_sent++;
		if (op == ksi_pkg::OP_START || op == ksi_pkg::OP_TICK
			|| (op == ksi_pkg::OP_APPEND && is_typeable(ch)))
			useful_items++;
	endfunction

	function automatic logic [7:0] pick_char();
		return typeable[$urandom_range(0, typeable.size() - 1)];
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] ch;
		case ($urandom_range(0, 3))
			0: ch = ksi_pkg::CHAR_CR;
			1: ch = 8'd128 + 8'($urandom_range(0, 127));
			2: begin
				ch = 8'($urandom_range(0, 127));
				while (is_typeable(ch))
					ch = 8'($urandom_range(0, 127));
			end
			default: ch = 8'($urandom_range(0, 255));
		endcase
		return ch;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			ksi_pkg::REG_HOLD:  hold_ticks = val;
			ksi_pkg::REG_GAP:   gap_ticks = val;
			ksi_pkg::REG_START: delay_ticks = val;
			default:   ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pending_beats.size() != 0 || key_events.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of random length, random gaps
	always @(negedge clk) begin
		logic     nv;
		in_beat_t nx;
		nv    = 1'b0;
		nx.op = s_axis_tuser;
		nx.ch = s_axis_tdata;
		if (s_axis_tvalid && in_fire)
			pending_beats.delete(0);
		if (s_axis_tvalid && !in_fire) begin
			nv = 1'b1;
		end else if (gap_left != 0) begin
			gap_left--;
		end else if (pending_beats.size() != 0) begin
			nv = 1'b1;
			nx = pending_beats[0];
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end
		s_axis_tvalid <= nv;
		s_axis_tuser  <= nx.op;
		s_axis_tdata  <= nx.ch;
	end

	// sink: ready follows one of four stall patterns, chosen at random
	always @(negedge clk) begin
		rx_cnt++;
		if (rx_cnt % 128 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= (rx_cnt % 3) != 0;
			2:       m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= (rx_cnt % 16) < 3;
		endcase
	end

	always @(posedge clk) begin
		key_event_t ev;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			advance_keyboard(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (key_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual tdata=%02h tlast=%0d",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				ev = key_events.pop_front();
				check_field("is_release", ev.rel, m_axis_tdata[0]);
				check_field("key_row", ev.row, m_axis_tdata[4:1]);
				check_field("key_col", ev.col, m_axis_tdata[7:5]);
				check_field("last", ev.last, m_axis_tlast);
				events_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d events outstanding", $time, key_events.size());
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int n;
		int ticks;
		int r;
		int base;
		for (int i = 0; i < 128; i++)
			key_table[i] = '0;
		for (int i = 0; i < 26; i++) begin
			put_key(8'h61 + i, LET_ROW[i], LET_COL[i], 1'b0);
			put_key(8'h41 + i, LET_ROW[i], LET_COL[i], 1'b1);
		end
		for (int i = 0; i < 10; i++)
			put_key(8'h30 + i, DIG_ROW[i], DIG_COL[i], 1'b0);
		put_key(8'h0A, 2, 2, 1'b0);
		put_key(8'h20, 5, 7, 1'b0);
		put_key(8'h2D, 3, 1, 1'b0);
		put_key(8'h3D, 3, 0, 1'b0);
		put_key(8'h3B, 3, 5, 1'b0);
		put_key(8'h27, 3, 4, 1'b0);
		put_key(8'h2F, 3, 6, 1'b0);
		put_key(8'h2E, 3, 7, 1'b0);
		put_key(8'h2C, 4, 7, 1'b0);
		put_key(8'h5B, 3, 2, 1'b0);
		put_key(8'h5D, 2, 1, 1'b0);
		put_key(8'h5C, 2, 6, 1'b0);
		put_key(8'h21, 8, 0, 1'b1);
		put_key(8'h22, 8, 1, 1'b1);
		put_key(8'h24, 7, 0, 1'b1);
		put_key(8'h25, 6, 1, 1'b1);
		put_key(8'h26, 6, 0, 1'b1);
		put_key(8'h28, 5, 0, 1'b1);
		put_key(8'h29, 4, 1, 1'b1);
		put_key(8'h3A, 3, 5, 1'b1);
		put_key(8'h3F, 3, 6, 1'b1);
		put_key(8'h3E, 3, 7, 1'b1);
		put_key(8'h3C, 4, 7, 1'b1);
		for (int i = 0; i < 128; i++)
			if (key_table[i].ok)
				typeable.push_back(8'(i));

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset settings; timer starts at zero with no start beat
		enqueue_beat(ksi_pkg::OP_TICK, 8'hFF);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'h61);
		enqueue_beat(ksi_pkg::OP_TICK, 8'h00);
		enqueue_beat(OP_UNUSED, 8'hFF);
		repeat (3) enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
		enqueue_beat(ksi_pkg::OP_APPEND, ksi_pkg::CHAR_CR);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'hFF);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'h00);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'h7F);
		enqueue_beat(ksi_pkg::OP_TICK, 8'h00);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'h62);
		repeat (2) enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
		enqueue_beat(ksi_pkg::OP_START, 8'hFF);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'h51);
		enqueue_beat(ksi_pkg::OP_APPEND, 8'h0A);
		repeat (9) enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
		settle();

		base = useful_items;
		while (useful_items - base < RANDOM_ITEMS) begin
			phases++;
			if (phases == 2) begin
				// longest timers: full start delay, then start while the key is held
				write_reg(ksi_pkg::REG_HOLD, 8'd255);
				write_reg(ksi_pkg::REG_GAP, 8'd255);
				write_reg(ksi_pkg::REG_START, 8'd255);
				enqueue_beat(ksi_pkg::OP_START, 8'($urandom_range(0, 255)));
				enqueue_beat(ksi_pkg::OP_APPEND, 8'h51);
				repeat (262) enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
				enqueue_beat(ksi_pkg::OP_START, 8'($urandom_range(0, 255)));
				enqueue_beat(ksi_pkg::OP_APPEND, 8'h77);
				repeat (4) enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
			end else if (phases == 4) begin
				// zero timers and an overfilled queue
				write_reg(ksi_pkg::REG_HOLD, 8'd0);
				write_reg(ksi_pkg::REG_GAP, 8'd0);
				write_reg(ksi_pkg::REG_START, 8'd0);
				enqueue_beat(ksi_pkg::OP_START, 8'($urandom_range(0, 255)));
				repeat (ksi_pkg::QUEUE_DEPTH + 4) enqueue_beat(ksi_pkg::OP_APPEND, pick_char());
				for (int i = 0; i < 60; i++) begin
					if (i % 20 == 7)
						enqueue_beat(ksi_pkg::OP_APPEND, pick_char());
					enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
				end
			end else begin
				r = ($urandom_range(0, 5) == 0) ? 12 : 3;
				write_reg(ksi_pkg::REG_HOLD, 8'($urandom_range(0, r)));
				write_reg(ksi_pkg::REG_GAP, 8'($urandom_range(0, r)));
				write_reg(ksi_pkg::REG_START, 8'($urandom_range(0, r)));
				if ($urandom_range(0, 9) != 0)
					enqueue_beat(ksi_pkg::OP_START, 8'($urandom_range(0, 255)));
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					enqueue_beat(ksi_pkg::OP_APPEND, ($urandom_range(0, 99) < 85)
						? pick_char() : noise_char());
				ticks = delay_ticks + n * (hold_ticks + gap_ticks + 2) + $urandom_range(0, 4);
				while (ticks > 0) begin
					r = $urandom_range(0, 99);
					if (r < 4)
						enqueue_beat(ksi_pkg::OP_APPEND, pick_char());
					else if (r < 6)
						enqueue_beat(OP_UNUSED, 8'($urandom_range(0, 255)));
					else if (r < 8)
						enqueue_beat(ksi_pkg::OP_APPEND, noise_char());
					else if (r == 8)
						enqueue_beat(ksi_pkg::OP_START, 8'($urandom_range(0, 255)));
					else begin
						enqueue_beat(ksi_pkg::OP_TICK, 8'($urandom_range(0, 255)));
						ticks--;
					end
				end
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (key_events.size() != 0) begin
			errors++;
			$display("%0t: %0d key events expected but never seen", $time, key_events.size());
		end
		$display("summary: %0d input beats over %0d timer settings, %0d key events compared",
			beats_sent, phases + 1, events_checked);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
